>>> design/frame_letterbox_center_crop_assert.svh
// assertion macros shared by the letterbox / center crop rtl
`ifndef FRAME_LETTERBOX_CENTER_CROP_ASSERT_SVH
`define FRAME_LETTERBOX_CENTER_CROP_ASSERT_SVH

// same-cycle implication
`define FLC_ASSERT_IMPLY(name, clk, rst, cond, expr) \
   name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("flc assertion failed");

// next-cycle implication
`define FLC_ASSERT_NEXT(name, clk, rst, cond, expr) \
   name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("flc assertion failed");

`endif

>>> design/flc_pkg.sv
// types and constants of the letterbox / center crop block
package flc_pkg;

   localparam int PIXEL_W     = 32;
   localparam int CFG_W       = 13;
   localparam int RL_W        = 25;
   localparam int CSR_INDEX_W = 8;

   typedef logic [PIXEL_W-1:0]     pixel_type;
   typedef logic [CFG_W-1:0]       cfg_type;
   typedef logic [RL_W-1:0]        run_len_type;
   typedef logic [CSR_INDEX_W-1:0] csr_index_type;

   localparam csr_index_type REG_SOURCE_WIDTH  = csr_index_type'(0);
   localparam csr_index_type REG_SOURCE_HEIGHT = csr_index_type'(1);
   localparam csr_index_type REG_TARGET_WIDTH  = csr_index_type'(2);
   localparam csr_index_type REG_TARGET_HEIGHT = csr_index_type'(3);

   localparam cfg_type RESET_WIDTH  = cfg_type'(640);
   localparam cfg_type RESET_HEIGHT = cfg_type'(480);

   localparam pixel_type BLACK = '0;

   // border fill lengths, precomputed from the configuration
   typedef struct packed {
      run_len_type left_len;
      run_len_type left_first_len;
      run_len_type right_len;
      run_len_type right_last_len;
      logic        left_nz;
      logic        left_first_nz;
      logic        right_nz;
      logic        right_last_nz;
   } runs_type;

   typedef struct packed {
      logic ready;
      logic restart;
   } geom_status_type;

   // results caused by one accepted item
   typedef struct packed {
      logic        pre_en;
      logic        pix_en;
      logic        post_en;
      logic        done;
      pixel_type   pix;
      run_len_type pre_len;
      run_len_type post_len;
   } item_type;

   typedef struct packed {
      logic        valid;
      pixel_type   out_value;
      logic        is_fill;
      run_len_type run_length;
      logic        frame_done;
      logic        last_of_run;
   } rsp_type;

endpackage

>>> design/flc_if.sv
// channel interfaces: pixel input, result output, register write
interface flc_req_if;
   import flc_pkg::*;
   logic      valid;
   logic      ready;
   pixel_type pixel_value;
   modport source(output valid, output pixel_value, input ready);
   modport sink(input valid, input pixel_value, output ready);
endinterface

interface flc_rsp_if;
   import flc_pkg::*;
   logic        valid;
   logic        ready;
   pixel_type   out_value;
   logic        is_fill;
   run_len_type run_length;
   logic        frame_done;
   logic        last_of_run;
   modport source(output valid, output out_value, output is_fill, output run_length,
                  output frame_done, output last_of_run, input ready);
   modport sink(input valid, input out_value, input is_fill, input run_length,
                input frame_done, input last_of_run, output ready);
endinterface

interface flc_csr_if;
   import flc_pkg::*;
   logic          valid;
   logic          ready;
   csr_index_type index;
   cfg_type       data;
   modport source(output valid, output index, output data, input ready);
   modport sink(input valid, input index, input data, output ready);
endinterface

>>> design/flc_geometry.sv
// configuration registers and two-stage derivation of the placement geometry
`include "frame_letterbox_center_crop_assert.svh"
module flc_geometry #(
   parameter int MAX_DIM = 4096,
   parameter int DW      = $clog2(MAX_DIM + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write,
   input  flc_pkg::csr_index_type   csr_index,
   input  flc_pkg::cfg_type         csr_data,
   output logic [DW-1:0]            c0,
   output logic [DW-1:0]            c_last,
   output logic [DW-1:0]            r0,
   output logic [DW-1:0]            r_last,
   output logic [DW-1:0]            sw,
   output logic [DW-1:0]            sh,
   output flc_pkg::runs_type        runs,
   output flc_pkg::geom_status_type status
);
   import flc_pkg::*;

   localparam int EW = (DW > CFG_W) ? DW : CFG_W;
   localparam int LW = 2 * DW + 1;
   localparam int PW = (LW > RL_W) ? LW : RL_W;
   localparam logic [1:0] SETTLE_CYCLES = 2'd2;

   function automatic logic [DW-1:0] clamp_dim(input cfg_type v);
      logic [EW-1:0] ve;
      begin
         ve = EW'(v);
         if (ve == '0) begin
            ve = EW'(1);
         end else if (ve > EW'(MAX_DIM)) begin
            ve = EW'(MAX_DIM);
         end
         return DW'(ve);
      end
   endfunction

   cfg_type source_width_ff, source_height_ff, target_width_ff, target_height_ff;
   logic [1:0] settle_ff, settle_in;
   logic restart;

   // stage a
   logic [DW-1:0] sw_in, sh_in, tw_in, c0_in, r0_in, c_last_in, r_last_in;
   logic [DW-1:0] hb_in, ha_in, vb_in, va_in;
   logic [DW-1:0] sw_ff, sh_ff, tw_ff, c0_ff, r0_ff, c_last_ff, r_last_ff;
   logic [DW-1:0] hb_ff, ha_ff, vb_ff, va_ff;
   // stage b
   logic [PW-1:0] left_first_wide, right_last_wide, left_wide, right_wide;
   runs_type runs_ff;

   always_comb begin
      restart = 1'b0;
      if (csr_write) begin
         unique case (csr_index) inside
            REG_SOURCE_WIDTH, REG_SOURCE_HEIGHT,
            REG_TARGET_WIDTH, REG_TARGET_HEIGHT: restart = 1'b1;
            default: restart = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         source_width_ff  <= RESET_WIDTH;
         source_height_ff <= RESET_HEIGHT;
         target_width_ff  <= RESET_WIDTH;
         target_height_ff <= RESET_HEIGHT;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_SOURCE_WIDTH:  source_width_ff  <= csr_data;
            REG_SOURCE_HEIGHT: source_height_ff <= csr_data;
            REG_TARGET_WIDTH:  target_width_ff  <= csr_data;
            REG_TARGET_HEIGHT: target_height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (restart) begin
         settle_in = SETTLE_CYCLES;
      end else if (settle_ff != '0) begin
         settle_in = settle_ff - 2'd1;
      end else begin
         settle_in = settle_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ff <= SETTLE_CYCLES;
      end else begin
         settle_ff <= settle_in;
      end
   end

   always_comb begin
      logic [DW-1:0] th, diff_h, diff_v, vw, vh;
      sw_in = clamp_dim(source_width_ff);
      sh_in = clamp_dim(source_height_ff);
      tw_in = clamp_dim(target_width_ff);
      th    = clamp_dim(target_height_ff);
      if (tw_in > sw_in) begin
         diff_h = tw_in - sw_in;
         ha_in  = diff_h >> 1;
         hb_in  = diff_h - ha_in;
         c0_in  = '0;
         vw     = sw_in;
      end else begin
         diff_h = sw_in - tw_in;
         ha_in  = '0;
         hb_in  = '0;
         c0_in  = diff_h >> 1;
         vw     = tw_in;
      end
      if (th > sh_in) begin
         diff_v = th - sh_in;
         va_in  = diff_v >> 1;
         vb_in  = diff_v - va_in;
         r0_in  = '0;
         vh     = sh_in;
      end else begin
         diff_v = sh_in - th;
         va_in  = '0;
         vb_in  = '0;
         r0_in  = diff_v >> 1;
         vh     = th;
      end
      c_last_in = c0_in + vw - DW'(1);
      r_last_in = r0_in + vh - DW'(1);
   end

   always_ff @(posedge clock) begin
      sw_ff     <= sw_in;
      sh_ff     <= sh_in;
      tw_ff     <= tw_in;
      c0_ff     <= c0_in;
      r0_ff     <= r0_in;
      c_last_ff <= c_last_in;
      r_last_ff <= r_last_in;
      hb_ff     <= hb_in;
      ha_ff     <= ha_in;
      vb_ff     <= vb_in;
      va_ff     <= va_in;
   end

   // top and bottom border rows fold into the side runs
   assign left_wide       = PW'(hb_ff);
   assign right_wide      = PW'(ha_ff);
   assign left_first_wide = PW'(hb_ff) + PW'(vb_ff) * PW'(tw_ff);
   assign right_last_wide = PW'(ha_ff) + PW'(va_ff) * PW'(tw_ff);

   always_ff @(posedge clock) begin
      runs_ff.left_len       <= left_wide[RL_W-1:0];
      runs_ff.right_len      <= right_wide[RL_W-1:0];
      runs_ff.left_first_len <= left_first_wide[RL_W-1:0];
      runs_ff.right_last_len <= right_last_wide[RL_W-1:0];
      runs_ff.left_nz        <= (left_wide != '0);
      runs_ff.right_nz       <= (right_wide != '0);
      runs_ff.left_first_nz  <= (left_first_wide != '0);
      runs_ff.right_last_nz  <= (right_last_wide != '0);
   end

   assign c0             = c0_ff;
   assign c_last         = c_last_ff;
   assign r0             = r0_ff;
   assign r_last         = r_last_ff;
   assign sw             = sw_ff;
   assign sh             = sh_ff;
   assign runs           = runs_ff;
   assign status.ready   = (settle_ff == '0);
   assign status.restart = restart;

   `FLC_ASSERT_NEXT(a_restart_blocks, clock, reset, restart, !status.ready)

endmodule

>>> design/flc_placer.sv
// source position counters and window decode of one item
`include "frame_letterbox_center_crop_assert.svh"
module flc_placer #(
   parameter int MAX_DIM = 4096,
   parameter int DW      = $clog2(MAX_DIM + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  flc_pkg::pixel_type       pixel_value,
   input  logic [DW-1:0]            c0,
   input  logic [DW-1:0]            c_last,
   input  logic [DW-1:0]            r0,
   input  logic [DW-1:0]            r_last,
   input  logic [DW-1:0]            sw,
   input  logic [DW-1:0]            sh,
   input  flc_pkg::runs_type        runs,
   input  flc_pkg::geom_status_type status,
   output flc_pkg::item_type        item
);
   import flc_pkg::*;

   localparam int CNT_W = $clog2(MAX_DIM);

   logic [CNT_W-1:0] col_ff, col_in, row_ff, row_in;
   logic [DW-1:0]    col, row, col_next, row_next;
   logic in_win, first_col, last_col, first_row, last_row;

   assign col      = DW'(col_ff);
   assign row      = DW'(row_ff);
   assign col_next = col + DW'(1);
   assign row_next = row + DW'(1);

   assign in_win    = (col >= c0) && (col <= c_last) && (row >= r0) && (row <= r_last);
   assign first_col = (col == c0);
   assign last_col  = (col == c_last);
   assign first_row = (row == r0);
   assign last_row  = (row == r_last);

   always_comb begin
      item.pix_en   = in_win;
      item.pix      = pixel_value;
      item.pre_len  = first_row ? runs.left_first_len : runs.left_len;
      item.post_len = last_row ? runs.right_last_len : runs.right_len;
      item.pre_en   = in_win && first_col &&
                      (first_row ? runs.left_first_nz : runs.left_nz);
      item.post_en  = in_win && last_col &&
                      (last_row ? runs.right_last_nz : runs.right_nz);
      item.done     = in_win && last_col && last_row;
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (status.restart) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (col_next >= sw) begin
            col_in = '0;
            row_in = (row_next >= sh) ? '0 : CNT_W'(row_next);
         end else begin
            col_in = CNT_W'(col_next);
            row_in = (row >= sh) ? '0 : row_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   `FLC_ASSERT_NEXT(a_restart_clears, clock, reset, status.restart,
                    (col_ff == '0) && (row_ff == '0))
   `FLC_ASSERT_IMPLY(a_col_in_frame, clock, reset, accept, col < sw)

endmodule

>>> design/flc_result_stage.sv
// result register bank of up to three results, emitted one per cycle while rsp_ready is high
`include "frame_letterbox_center_crop_assert.svh"
module flc_result_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  flc_pkg::item_type  item,
   input  logic               rsp_ready,
   output logic               can_load,
   output flc_pkg::rsp_type   rsp
);
   import flc_pkg::*;

   // bit 0 leading fill, bit 1 pixel, bit 2 trailing fill
   logic [2:0]  pend_ff, pend_in, pend_low, pend_rest;
   pixel_type   pix_ff;
   run_len_type pre_len_ff, post_len_ff;
   logic        done_ff;
   logic        pop;

   assign pend_low  = pend_ff & ~(pend_ff - 3'd1);
   assign pend_rest = pend_ff & ~pend_low;
   assign pop       = rsp.valid && rsp_ready;
   assign can_load  = (pend_ff == '0) || (rsp_ready && (pend_rest == '0));

   always_comb begin
      rsp.valid       = (pend_ff != '0);
      rsp.out_value   = pend_low[1] ? pix_ff : BLACK;
      rsp.is_fill     = !pend_low[1];
      rsp.last_of_run = (pend_rest == '0);
      rsp.frame_done  = (pend_rest == '0) && done_ff;
      if (pend_low[0]) begin
         rsp.run_length = pre_len_ff;
      end else if (pend_low[1]) begin
         rsp.run_length = run_len_type'(1);
      end else begin
         rsp.run_length = post_len_ff;
      end
   end

   always_comb begin
      if (load) begin
         pend_in = {item.post_en, item.pix_en, item.pre_en};
      end else if (pop) begin
         pend_in = pend_rest;
      end else begin
         pend_in = pend_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         pix_ff      <= item.pix;
         pre_len_ff  <= item.pre_len;
         post_len_ff <= item.post_len;
         done_ff     <= item.done;
      end
   end

   `FLC_ASSERT_IMPLY(a_fill_has_pixel, clock, reset, pend_ff[0], pend_ff[1])
   `FLC_ASSERT_IMPLY(a_done_is_last, clock, reset, rsp.valid && rsp.frame_done,
                     rsp.last_of_run)

endmodule

>>> design/frame_letterbox_center_crop.sv
// top level of the letterbox / center crop pixel placer
// usage:
//   req_if carries one source pixel per item in raster order. each kept pixel
//   gives one to three results on rsp_if: an optional leading black fill run,
//   the pixel itself, an optional trailing black fill run. dropped (cropped)
//   pixels give no result. run_length counts destination pixels; frame_done
//   marks the final result of the destination frame.
//   csr_if writes source_width (0), source_height (1), target_width (2) and
//   target_height (3); a write to one of those restarts the frame at pixel 0.
//   csr_ready is always high; other indexes are taken and ignored.
// timing:
//   a result appears the cycle after its item is accepted. throughput is one
//   item per cycle while each item gives at most one result and rsp_ready is
//   high; an item with several results holds req_ready low until its last
//   result is leaving, as the result bank drains one result per ready cycle.
//   after reset or a register write, req_ready stays low while the two-stage
//   geometry pipeline (offsets, then border run products) settles.
// stall:
//   while rsp_ready is low the pending results hold; a new item is taken in
//   the same cycle that the last pending result leaves.
module frame_letterbox_center_crop #(
   parameter int MAX_DIM = 4096
) (
   input logic       clock,
   input logic       reset,
   flc_req_if.sink   req_if,
   flc_rsp_if.source rsp_if,
   flc_csr_if.sink   csr_if
);
   import flc_pkg::*;

   localparam int DW = $clog2(MAX_DIM + 1);

   // geometry outputs
   logic [DW-1:0]   c0, c_last, r0, r_last, sw, sh;
   runs_type        runs;
   geom_status_type status;

   // handshake glue
   logic     accept;
   logic     can_load;
   logic     csr_write;
   item_type item;
   rsp_type  rsp;

   // register port never stalls
   assign csr_if.ready = 1'b1;
   assign csr_write    = csr_if.valid;

   // take an item only with settled geometry and room in the result bank
   assign req_if.ready = status.ready && can_load;
   assign accept       = req_if.valid && req_if.ready;

   flc_geometry #(
      .MAX_DIM (MAX_DIM),
      .DW      (DW)
   ) u_geometry (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_if.index),
      .csr_data  (csr_if.data),
      .c0        (c0),
      .c_last    (c_last),
      .r0        (r0),
      .r_last    (r_last),
      .sw        (sw),
      .sh        (sh),
      .runs      (runs),
      .status    (status)
   );

   // position counters and decode of the current item
   flc_placer #(
      .MAX_DIM (MAX_DIM),
      .DW      (DW)
   ) u_placer (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .pixel_value (req_if.pixel_value),
      .c0          (c0),
      .c_last      (c_last),
      .r0          (r0),
      .r_last      (r_last),
      .sw          (sw),
      .sh          (sh),
      .runs        (runs),
      .status      (status),
      .item        (item)
   );

   // result bank, drains one result per cycle while rsp_ready is high
   flc_result_stage u_result_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .item      (item),
      .rsp_ready (rsp_if.ready),
      .can_load  (can_load),
      .rsp       (rsp)
   );

   assign rsp_if.valid       = rsp.valid;
   assign rsp_if.out_value   = rsp.out_value;
   assign rsp_if.is_fill     = rsp.is_fill;
   assign rsp_if.run_length  = rsp.run_length;
   assign rsp_if.frame_done  = rsp.frame_done;
   assign rsp_if.last_of_run = rsp.last_of_run;

endmodule

>>> tb/frame_letterbox_center_crop_checker.sv
// checker for the letterbox / center crop placer: predicts destination writes and compares them
module frame_letterbox_center_crop_checker #(
   parameter int MAX_DIM = 4096
) (
   input  logic clock,
   input  logic reset,
   flc_req_if   req_if,
   flc_rsp_if   rsp_if,
   flc_csr_if   csr_if,
   output int   fail_count,
   output int   outstanding,
   output int   checked_count
);
   timeunit 1ns;
   timeprecision 1ps;

   import flc_pkg::*;

   typedef struct packed {
      pixel_type   out_value;
      logic        is_fill;
      run_len_type run_length;
      logic        frame_done;
      logic        last_of_run;
   } dest_write_type;

   cfg_type        src_w_reg;
   cfg_type        src_h_reg;
   cfg_type        dst_w_reg;
   cfg_type        dst_h_reg;
   int unsigned    col_pos;
   int unsigned    row_pos;
   dest_write_type dest_writes_q[$];

   function automatic int unsigned clamp_dim(input cfg_type v);
      if (v == 0) return 1;
      if (v > MAX_DIM) return MAX_DIM;
      return v;
   endfunction

   function automatic dest_write_type make_write(input pixel_type v, input logic fill,
                                                 input longint unsigned len);
      dest_write_type w;
      w.out_value   = v;
      w.is_fill     = fill;
      w.run_length  = run_len_type'(len);
      w.frame_done  = 1'b0;
      w.last_of_run = 1'b0;
      return w;
   endfunction

   // destination writes caused by one source pixel, then counter advance
   task automatic place_pixel(input pixel_type pix);
      int unsigned     sw, sh, tw, th, vw, vh, c0, r0, hb, ha, vb, va;
      longint unsigned len;
      logic            first_row, last_row, last_col;
      dest_write_type  burst[$];
      sw = clamp_dim(src_w_reg);
      sh = clamp_dim(src_h_reg);
      tw = clamp_dim(dst_w_reg);
      th = clamp_dim(dst_h_reg);
      c0 = 0; r0 = 0; hb = 0; ha = 0; vb = 0; va = 0;
      if (tw > sw) begin
         ha = (tw - sw) >> 1;
         hb = (tw - sw) - ha;
         vw = sw;
      end else begin
         c0 = (sw - tw) >> 1;
         vw = tw;
      end
      if (th > sh) begin
         va = (th - sh) >> 1;
         vb = (th - sh) - va;
         vh = sh;
      end else begin
         r0 = (sh - th) >> 1;
         vh = th;
      end
      if (col_pos >= c0 && col_pos < c0 + vw && row_pos >= r0 && row_pos < r0 + vh) begin
         first_row = (row_pos == r0);
         last_row  = (row_pos == r0 + vh - 1);
         last_col  = (col_pos == c0 + vw - 1);
         if (col_pos == c0) begin
            len = hb;
            if (first_row) len += longint'(vb) * longint'(tw);
            if (len != 0) burst.push_back(make_write(BLACK, 1'b1, len));
         end
         burst.push_back(make_write(pix, 1'b0, 1));
         if (last_col) begin
            len = ha;
            if (last_row) len += longint'(va) * longint'(tw);
            if (len != 0) burst.push_back(make_write(BLACK, 1'b1, len));
            if (last_row) burst[burst.size()-1].frame_done = 1'b1;
         end
         burst[burst.size()-1].last_of_run = 1'b1;
         foreach (burst[i]) dest_writes_q.push_back(burst[i]);
      end
      if (col_pos + 1 >= sw) begin
         col_pos = 0;
         row_pos = (row_pos + 1 >= sh) ? 0 : row_pos + 1;
      end else begin
         col_pos = col_pos + 1;
         row_pos = (row_pos >= sh) ? 0 : row_pos;
      end
   endtask

   task automatic apply_reg_write(input csr_index_type idx, input cfg_type val);
      case (idx)
         REG_SOURCE_WIDTH:  src_w_reg = val;
         REG_SOURCE_HEIGHT: src_h_reg = val;
         REG_TARGET_WIDTH:  dst_w_reg = val;
         REG_TARGET_HEIGHT: dst_h_reg = val;
         default:           return;
      endcase
      col_pos = 0;
      row_pos = 0;
   endtask

   task automatic compare_write();
      dest_write_type got, want;
      got.out_value   = rsp_if.out_value;
      got.is_fill     = rsp_if.is_fill;
      got.run_length  = rsp_if.run_length;
      got.frame_done  = rsp_if.frame_done;
      got.last_of_run = rsp_if.last_of_run;
      if (dest_writes_q.size() == 0) begin
         $error("unexpected result: out_value %h is_fill %0b run_length %0d",
                got.out_value, got.is_fill, got.run_length);
         fail_count++;
         return;
      end
      want = dest_writes_q.pop_front();
      checked_count++;
      if (got.out_value !== want.out_value) begin
         $error("out_value: expected %h, actual %h", want.out_value, got.out_value);
         fail_count++;
      end
      if (got.is_fill !== want.is_fill) begin
         $error("is_fill: expected %0b, actual %0b", want.is_fill, got.is_fill);
         fail_count++;
      end
      if (got.run_length !== want.run_length) begin
         $error("run_length: expected %0d, actual %0d", want.run_length, got.run_length);
         fail_count++;
      end
      if (got.frame_done !== want.frame_done) begin
         $error("frame_done: expected %0b, actual %0b", want.frame_done, got.frame_done);
         fail_count++;
      end
      if (got.last_of_run !== want.last_of_run) begin
         $error("last_of_run: expected %0b, actual %0b", want.last_of_run, got.last_of_run);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         src_w_reg     = RESET_WIDTH;
         src_h_reg     = RESET_HEIGHT;
         dst_w_reg     = RESET_WIDTH;
         dst_h_reg     = RESET_HEIGHT;
         col_pos       = 0;
         row_pos       = 0;
         fail_count    = 0;
         checked_count = 0;
         dest_writes_q.delete();
      end else begin
         if (rsp_if.valid && rsp_if.ready) compare_write();
         if (req_if.valid && req_if.ready) place_pixel(req_if.pixel_value);
         if (csr_if.valid && csr_if.ready) apply_reg_write(csr_if.index, csr_if.data);
      end
      outstanding <= dest_writes_q.size();
   end

endmodule

>>> tb/frame_letterbox_center_crop_tb.sv
// testbench top of the letterbox / center crop placer: stimulus, idling and verdict
module frame_letterbox_center_crop_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import flc_pkg::*;

   localparam int MAX_DIM = 4096;

   logic clock;
   logic reset;

   flc_req_if req_if();
   flc_rsp_if rsp_if();
   flc_csr_if csr_if();

   // checker outputs
   int fail_count;
   int outstanding;
   int checked_count;

   // idling mix, percent of cycles
   int idle_pct;
   int stall_pct;

   // bookkeeping for the summary
   int pixels_sent;
   int reg_writes;

   frame_letterbox_center_crop #(
      .MAX_DIM(MAX_DIM)
   ) i_dut (
      .clock (clock),
      .reset (reset),
      .req_if(req_if),
      .rsp_if(rsp_if),
      .csr_if(csr_if)
   );

   frame_letterbox_center_crop_checker #(
      .MAX_DIM(MAX_DIM)
   ) i_checker (
      .clock        (clock),
      .reset        (reset),
      .req_if       (req_if),
      .rsp_if       (rsp_if),
      .csr_if       (csr_if),
      .fail_count   (fail_count),
      .outstanding  (outstanding),
      .checked_count(checked_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      #2000000;
      $display("status: fail");
      $finish;
   end

   // receiver side: ready drops in stall_pct of the cycles
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_if.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // one register write; valid goes low again before the next write
   task automatic write_reg(input csr_index_type idx, input cfg_type val);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= val;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      reg_writes++;
      @(posedge clock);
   endtask

   // stop sending and wait until every expected result is out
   task automatic wait_drained();
      int guard;
      guard = 0;
      req_if.valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (outstanding != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      // dropped pixels give no result but may still be in flight
      repeat (6) @(posedge clock);
   endtask

   // one source pixel item; valid stays high if the next item follows at once
   task automatic send_pixel(input pixel_type v);
      while ($urandom_range(99) < idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.pixel_value <= v;
      do @(posedge clock); while (!req_if.ready);
      pixels_sent++;
   endtask

   // new geometry, only while the block is idle
   task automatic program_frame(input cfg_type sw, input cfg_type sh,
                                input cfg_type tw, input cfg_type th);
      wait_drained();
      write_reg(REG_SOURCE_WIDTH, sw);
      write_reg(REG_SOURCE_HEIGHT, sh);
      write_reg(REG_TARGET_WIDTH, tw);
      write_reg(REG_TARGET_HEIGHT, th);
   endtask

   // mostly tiny frames so that rows and frames close often
   function automatic cfg_type rand_dim();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 80) return cfg_type'($urandom_range(1, 6));
      if (r < 88) return cfg_type'(0);
      if (r < 94) return cfg_type'($urandom_range(7, 40));
      return cfg_type'($urandom_range(4096, 8191));
   endfunction

   initial begin : stimulus
      int n_pix;
      reset              <= 1'b1;
      req_if.valid       <= 1'b0;
      req_if.pixel_value <= '0;
      csr_if.valid       <= 1'b0;
      csr_if.index       <= REG_SOURCE_WIDTH;
      csr_if.data        <= '0;
      idle_pct    = 0;
      stall_pct   = 0;
      pixels_sent = 0;
      reg_writes  = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset geometry: equal source and target, plain copy
      send_pixel(pixel_type'(0));
      send_pixel('1);
      send_pixel(pixel_type'($urandom));

      // single pixel in the widest target, zero height reads as one row
      program_frame(cfg_type'(1), cfg_type'(1), cfg_type'(8191), cfg_type'(0));
      send_pixel(pixel_type'(32'haaaa_aaaa));
      send_pixel(pixel_type'(32'h5555_5555));

      // saturated source width over a maximal target: huge top border run
      program_frame(cfg_type'(8191), cfg_type'(0), cfg_type'(4096), cfg_type'(4096));
      send_pixel('1);
      send_pixel(pixel_type'(0));

      // 3x3 source cropped down to its center pixel
      program_frame(cfg_type'(3), cfg_type'(3), cfg_type'(1), cfg_type'(1));
      for (int k = 0; k < 9; k++) send_pixel(pixel_type'($urandom));

      // 2x2 in 5x5: odd border, larger half on top and left
      program_frame(cfg_type'(2), cfg_type'(2), cfg_type'(5), cfg_type'(5));
      // index past the register list must not restart the frame
      write_reg(csr_index_type'(200), cfg_type'(1));
      for (int k = 0; k < 4; k++) send_pixel(pixel_type'($urandom));

      // random geometry and pixels under each idling mix
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 83; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 83; end
            default: begin idle_pct = 24; stall_pct = 24; end
         endcase
         repeat (3) begin
            program_frame(rand_dim(), rand_dim(), rand_dim(), rand_dim());
            if ($urandom_range(3) == 0)
               write_reg(csr_index_type'($urandom_range(255, 4)), cfg_type'($urandom));
            n_pix = $urandom_range(7, 11);
            for (int k = 0; k < n_pix; k++) begin
               // hold off the sender once until the block has emptied
               if (phase == 1 && k == n_pix / 2) wait_drained();
               send_pixel(pixel_type'($urandom));
            end
         end
      end

      wait_drained();
      if (outstanding != 0) $error("%0d expected results never arrived", outstanding);

      $display("covered %0d pixel items and %0d register writes, %0d results checked",
               pixels_sent, reg_writes, checked_count);
      $display("geometry ran from 1x1 to saturated 4096, with crop, letterbox and mixed idling");
      if (fail_count == 0 && outstanding == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

>>> filelist.f
+incdir+design
design/flc_pkg.sv
design/flc_if.sv
design/flc_geometry.sv
design/flc_placer.sv
design/flc_result_stage.sv
design/frame_letterbox_center_crop.sv
tb/frame_letterbox_center_crop_checker.sv
tb/frame_letterbox_center_crop_tb.sv
